FILE: src/hstrps_pkg.sv
// Shared types and constants for the short-term reference picture set parser.
// Used by hstrps_golomb and hevc_short_term_rps_parser; depends on nothing.
package hstrps_pkg;

	localparam int DpbSize = 16;
	localparam int MaxSets = 64;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_COUNT   = 3'd1;
	localparam logic [2:0] ST_REF     = 3'd2;
	localparam logic [2:0] ST_MANY    = 3'd3;
	localparam logic [2:0] ST_RANGE   = 3'd4;
	localparam logic [2:0] ST_RESTART = 3'd5;

	typedef struct packed {
		logic       stream_bit;
		logic       begin_set;
		logic [6:0] target_set;
		logic       slice_mode;
	} cmd_t;

	typedef struct packed {
		logic [6:0]         set_out;
		logic               list_select;
		logic [3:0]         entry_position;
		logic signed [15:0] poc_delta;
		logic               used_now;
		logic               entry_valid;
		logic [2:0]         status;
		logic               last;
	} result_t;

	typedef struct packed {
		logic        done;
		logic        too_long;
		logic [31:0] value;
	} golomb_res_t;

	function automatic result_t make_err(input logic [6:0] slot, input logic [2:0] code);
		result_t r;
		r = '0;
		r.set_out = slot;
		r.status = code;
		r.last = 1'b1;
		return r;
	endfunction

endpackage

FILE: src/hstrps_golomb.sv
// Bit-serial Exp-Golomb decoder that takes one code bit per enabled cycle.
// Depends on hstrps_pkg for the result struct.
module hstrps_golomb (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     clr,
	input  logic                     bit_in,
	output hstrps_pkg::golomb_res_t  res
);

	logic [5:0]  zc_q, zc_n, zc;
	logic        suf_q, suf_n, suf;
	logic [4:0]  left_q, left_n, left;
	logic [31:0] acc_q, acc_n, acc;

	always_comb begin
		zc = clr ? 6'd0 : zc_q;
		suf = clr ? 1'b0 : suf_q;
		left = clr ? 5'd0 : left_q;
		acc = clr ? 32'd0 : acc_q;
		zc_n = zc;
		suf_n = suf;
		left_n = left;
		acc_n = acc;
		res = '0;
		if (en) begin
			if (!suf) begin
				if (bit_in) begin
					if (zc == 6'd0) begin
						res.done = 1'b1;
					end else begin
						suf_n = 1'b1;
						left_n = zc[4:0];
						acc_n = 32'd1;
					end
				end else begin
					zc_n = zc + 6'd1;
					if (zc_n > 6'd31) begin
						res.too_long = 1'b1;
					end
				end
			end else begin
				acc_n = {acc[30:0], bit_in};
				left_n = left - 5'd1;
				if (left_n == 5'd0) begin
					res.done = 1'b1;
					res.value = acc_n - 32'd1;
				end
			end
			if (res.done || res.too_long) begin
				zc_n = '0;
				suf_n = 1'b0;
				left_n = '0;
				acc_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zc_q <= '0;
			suf_q <= 1'b0;
			left_q <= '0;
			acc_q <= '0;
		end else begin
			zc_q <= zc_n;
			suf_q <= suf_n;
			left_q <= left_n;
			acc_q <= acc_n;
		end
	end

endmodule

FILE: src/hevc_short_term_rps_parser.sv
// Top level of the short-term reference picture set parser: bit sequencer,
// set table memories, inter-set derivation walk and result emission.
// Depends on hstrps_pkg and hstrps_golomb.
// Throughput: one syntax bit per cycle while a set is being read.
// A finished direct set emits its results through the S_EMIT_RD and S_EMIT_OUT states (one result for an empty set).
// Inter prediction visits each reference element and each step check in turn through S_DRV_RD and S_DRV_EV.
// Results are registered and cannot be stalled.
// Reset clears all control state; the set table holds garbage until written.
module hevc_short_term_rps_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  hstrps_pkg::cmd_t     cmd,
	input  logic                 cfg_we,
	input  logic [6:0]           cfg_data,
	output logic                 done,
	output hstrps_pkg::result_t  result
);

	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_INTER = 4'd1;
	localparam logic [3:0] PH_NNEG = 4'd2;
	localparam logic [3:0] PH_NPOS = 4'd3;
	localparam logic [3:0] PH_S0D = 4'd4;
	localparam logic [3:0] PH_S0U = 4'd5;
	localparam logic [3:0] PH_S1D = 4'd6;
	localparam logic [3:0] PH_S1U = 4'd7;
	localparam logic [3:0] PH_DIDX = 4'd8;
	localparam logic [3:0] PH_SIGN = 4'd9;
	localparam logic [3:0] PH_ABS = 4'd10;
	localparam logic [3:0] PH_UBC = 4'd11;
	localparam logic [3:0] PH_UD = 4'd12;

	localparam logic [2:0] S_RUN = 3'd0;
	localparam logic [2:0] S_ERR2 = 3'd1;
	localparam logic [2:0] S_DRV_RD = 3'd2;
	localparam logic [2:0] S_DRV_EV = 3'd3;
	localparam logic [2:0] S_EMIT_RD = 3'd4;
	localparam logic [2:0] S_EMIT_OUT = 3'd5;

	localparam logic [4:0] DPB5 = 5'(hstrps_pkg::DpbSize);
	localparam logic [4:0] OVER5 = 5'(hstrps_pkg::DpbSize + 1);
	localparam logic [6:0] MAXS7 = 7'(hstrps_pkg::MaxSets);

	logic [2:0]  state_q, state_d;
	logic [3:0]  ph_q, ph_d;
	logic [6:0]  cfg_q, work_slot_q, work_slot_d, ref_slot_q, ref_slot_d, err_slot_q, err_slot_d;
	logic        slice_q, slice_d, sign_q, sign_d;
	logic [4:0]  neg_q, neg_d, pos_q, pos_d, ref_neg_q, ref_neg_d, ref_pos_q, ref_pos_d;
	logic [4:0]  nl_q, nl_d, nh_q, nh_d;
	logic [15:0] poc_q, poc_d, step_q, step_d;
	logic [5:0]  loop_q, loop_d;
	logic [2:0]  pass_q, pass_d;
	logic [4:0]  kcnt_q, kcnt_d;
	logic        em_list_q, em_list_d;
	logic [3:0]  em_pos_q, em_pos_d;
	hstrps_pkg::result_t out_q, out_d;
	logic        stb_q, stb_d;

	logic [16:0] dmem [0:2079];
	logic [16:0] drd_q;
	logic        dm_we;
	logic [11:0] dm_wa, dm_ra;
	logic [16:0] dm_wd;
	logic [9:0]  cmem [0:64];
	logic [9:0]  crd_q;
	logic        cm_we;
	logic [6:0]  cm_wa;
	logic [9:0]  cm_wd;
	logic [1:0]  fmem [0:32];
	logic [1:0]  frd_q;
	logic        fm_we;
	logic [5:0]  fm_wa, fm_ra;
	logic [1:0]  fm_wd;

	logic        accept, begin_ok, go, g_en, g_clr;
	logic [6:0]  eff_sets;
	logic [3:0]  start_ph, p_eff;
	hstrps_pkg::golomb_res_t gres;

	logic [4:0]  drv_len, drv_k;
	logic        drv_list, drv_step, drv_hi;
	logic [5:0]  drv_fidx;

	assign busy = state_q != S_RUN;
	assign done = stb_q;
	assign result = out_q;

	always_comb begin
		eff_sets = (cfg_q > MAXS7) ? MAXS7 : cfg_q;
		accept = start && !busy;
		begin_ok = accept && cmd.begin_set && (cmd.target_set <= MAXS7);
		start_ph = (cmd.slice_mode ? (eff_sets != 7'd0) : (cmd.target_set != 7'd0))
			? PH_INTER : PH_NNEG;
		p_eff = begin_ok ? start_ph : ph_q;
		go = begin_ok || (accept && !cmd.begin_set && (ph_q != PH_IDLE));
		g_en = go && (p_eff == PH_NNEG || p_eff == PH_NPOS || p_eff == PH_S0D ||
			p_eff == PH_S1D || p_eff == PH_DIDX || p_eff == PH_ABS);
		g_clr = accept && cmd.begin_set;
	end

	hstrps_golomb u_golomb (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (g_en),
		.clr    (g_clr),
		.bit_in (cmd.stream_bit),
		.res    (gres)
	);

	always_comb begin
		drv_list = (pass_q == 3'd0) || (pass_q == 3'd5);
		drv_step = (pass_q == 3'd1) || (pass_q == 3'd4);
		drv_hi = pass_q >= 3'd3;
		case (pass_q)
			3'd0, 3'd5: drv_len = ref_pos_q;
			3'd2, 3'd3: drv_len = ref_neg_q;
			default: drv_len = 5'd1;
		endcase
		if (pass_q == 3'd0 || pass_q == 3'd3) begin
			drv_k = drv_len - 5'd1 - kcnt_q;
		end else begin
			drv_k = kcnt_q;
		end
		if (drv_step) begin
			drv_fidx = {1'b0, ref_neg_q} + {1'b0, ref_pos_q};
		end else if (drv_list) begin
			drv_fidx = {1'b0, ref_neg_q} + {1'b0, drv_k};
		end else begin
			drv_fidx = {1'b0, drv_k};
		end
	end

	always_comb begin
		logic [6:0]  ws;
		logic [4:0]  neg, pos, nl, nh, n;
		logic [15:0] poc;
		logic [5:0]  loop;
		logic        restarted, lst;
		logic [16:0] m17, dp;
		logic [17:0] sum;
		logic [31:0] v;
		logic        ok;

		state_d = state_q;
		ph_d = ph_q;
		work_slot_d = work_slot_q;
		ref_slot_d = ref_slot_q;
		err_slot_d = err_slot_q;
		slice_d = slice_q;
		sign_d = sign_q;
		neg_d = neg_q;
		pos_d = pos_q;
		ref_neg_d = ref_neg_q;
		ref_pos_d = ref_pos_q;
		nl_d = nl_q;
		nh_d = nh_q;
		poc_d = poc_q;
		step_d = step_q;
		loop_d = loop_q;
		pass_d = pass_q;
		kcnt_d = kcnt_q;
		em_list_d = em_list_q;
		em_pos_d = em_pos_q;
		out_d = out_q;
		stb_d = 1'b0;
		dm_we = 1'b0;
		dm_wa = '0;
		dm_wd = '0;
		dm_ra = {ref_slot_q, drv_list, drv_k[3:0]};
		cm_we = 1'b0;
		cm_wa = '0;
		cm_wd = '0;
		fm_we = 1'b0;
		fm_wa = loop_q;
		fm_wd = '0;
		fm_ra = drv_fidx;
		ws = work_slot_q;
		neg = neg_q;
		pos = pos_q;
		nl = nl_q;
		nh = nh_q;
		n = '0;
		poc = poc_q;
		loop = loop_q;
		restarted = 1'b0;
		lst = 1'b0;
		m17 = '0;
		dp = '0;
		sum = '0;
		v = gres.value;
		ok = 1'b0;

		case (state_q)
			S_RUN: begin
				if (accept && cmd.begin_set) begin
					if (ph_q != PH_IDLE) begin
						out_d = hstrps_pkg::make_err(work_slot_q, hstrps_pkg::ST_RESTART);
						stb_d = 1'b1;
						restarted = 1'b1;
					end
					ph_d = PH_IDLE;
					if (!begin_ok) begin
						if (restarted) begin
							err_slot_d = cmd.target_set;
							state_d = S_ERR2;
						end else begin
							out_d = hstrps_pkg::make_err(cmd.target_set, hstrps_pkg::ST_RANGE);
							stb_d = 1'b1;
						end
					end else begin
						ws = cmd.target_set;
						slice_d = cmd.slice_mode;
						cm_we = 1'b1;
						cm_wa = cmd.target_set;
						cm_wd = '0;
						neg = '0;
						pos = '0;
						poc = '0;
						loop = '0;
					end
				end
				if (go) begin
					ph_d = p_eff;
					case (p_eff)
						PH_INTER: begin
							if (!cmd.stream_bit) begin
								ph_d = PH_NNEG;
							end else if (slice_d) begin
								ph_d = PH_DIDX;
							end else begin
								ref_slot_d = ws - 7'd1;
								ph_d = PH_SIGN;
							end
						end
						PH_SIGN: begin
							sign_d = cmd.stream_bit;
							ph_d = PH_ABS;
						end
						PH_S0U, PH_S1U: begin
							dm_we = 1'b1;
							dm_wa = {ws, p_eff == PH_S1U, loop[3:0]};
							dm_wd = {cmd.stream_bit, poc};
							loop = loop + 6'd1;
							if (p_eff == PH_S0U) begin
								if (loop < {1'b0, neg}) begin
									ph_d = PH_S0D;
								end else begin
									poc = '0;
									loop = '0;
									if (pos != 5'd0) begin
										ph_d = PH_S1D;
									end else begin
										lst = 1'b1;
									end
								end
							end else if (loop < {1'b0, pos}) begin
								ph_d = PH_S1D;
							end else begin
								lst = 1'b1;
							end
						end
						PH_UBC, PH_UD: begin
							fm_we = 1'b1;
							fm_wa = loop;
							if (p_eff == PH_UBC) begin
								fm_wd = cmd.stream_bit ? 2'b11 : 2'b00;
							end else begin
								fm_wd = {cmd.stream_bit, 1'b0};
							end
							if (p_eff == PH_UBC && !cmd.stream_bit) begin
								ph_d = PH_UD;
							end else begin
								loop = loop + 6'd1;
								if (loop > ({1'b0, ref_neg_q} + {1'b0, ref_pos_q})) begin
									ph_d = PH_IDLE;
									nl = '0;
									nh = '0;
									pass_d = '0;
									kcnt_d = '0;
									state_d = S_DRV_RD;
								end else begin
									ph_d = PH_UBC;
								end
							end
						end
						default: begin
							if (gres.too_long) begin
								ph_d = PH_IDLE;
								out_d = hstrps_pkg::make_err(ws, hstrps_pkg::ST_RANGE);
								stb_d = 1'b1;
							end else if (gres.done) begin
								case (p_eff)
									PH_NNEG: begin
										neg = (v > 32'(hstrps_pkg::DpbSize)) ? OVER5 : v[4:0];
										ph_d = PH_NPOS;
									end
									PH_NPOS: begin
										pos = (v > 32'(hstrps_pkg::DpbSize)) ? OVER5 : v[4:0];
										if (neg > DPB5 || pos > DPB5) begin
											ph_d = PH_IDLE;
											out_d = hstrps_pkg::make_err(ws, hstrps_pkg::ST_COUNT);
											stb_d = 1'b1;
										end else begin
											poc = '0;
											loop = '0;
											if (neg != 5'd0) begin
												ph_d = PH_S0D;
											end else if (pos != 5'd0) begin
												ph_d = PH_S1D;
											end else begin
												lst = 1'b1;
											end
										end
									end
									PH_S0D, PH_S1D: begin
										m17 = {1'b0, v[15:0]} + 17'd1;
										if (p_eff == PH_S0D) begin
											sum = {{2{poc[15]}}, poc} - {1'b0, m17};
										end else begin
											sum = {{2{poc[15]}}, poc} + {1'b0, m17};
										end
										if (v[31:16] != 16'd0 || sum[17] != sum[15] ||
											sum[16] != sum[15]) begin
											ph_d = PH_IDLE;
											out_d = hstrps_pkg::make_err(ws, hstrps_pkg::ST_RANGE);
											stb_d = 1'b1;
										end else begin
											poc = sum[15:0];
											ph_d = (p_eff == PH_S0D) ? PH_S0U : PH_S1U;
										end
									end
									PH_DIDX: begin
										if (v >= {25'd0, eff_sets}) begin
											ph_d = PH_IDLE;
											out_d = hstrps_pkg::make_err(ws, hstrps_pkg::ST_REF);
											stb_d = 1'b1;
										end else begin
											ref_slot_d = eff_sets - v[6:0] - 7'd1;
											ph_d = PH_SIGN;
										end
									end
									PH_ABS: begin
										m17 = {1'b0, v[15:0]} + 17'd1;
										ok = (v[31:16] == 16'd0) &&
											(sign_q ? (m17 <= 17'd32768) : (m17 <= 17'd32767));
										if (!ok) begin
											ph_d = PH_IDLE;
											out_d = hstrps_pkg::make_err(ws, hstrps_pkg::ST_RANGE);
											stb_d = 1'b1;
										end else begin
											step_d = sign_q ? 16'(~m17 + 17'd1) : m17[15:0];
											ref_neg_d = (crd_q[4:0] > DPB5) ? DPB5 : crd_q[4:0];
											ref_pos_d = (crd_q[9:5] > DPB5) ? DPB5 : crd_q[9:5];
											loop = '0;
											ph_d = PH_UBC;
										end
									end
									default: begin
										ph_d = PH_IDLE;
									end
								endcase
							end
						end
					endcase
					if (lst) begin
						ph_d = PH_IDLE;
						cm_we = 1'b1;
						cm_wa = ws;
						cm_wd = {pos, neg};
						nl = neg;
						nh = pos;
						em_list_d = (neg == 5'd0);
						em_pos_d = '0;
						state_d = S_EMIT_RD;
					end
				end
				work_slot_d = ws;
				neg_d = neg;
				pos_d = pos;
				poc_d = poc;
				loop_d = loop;
				nl_d = nl;
				nh_d = nh;
			end
			S_ERR2: begin
				out_d = hstrps_pkg::make_err(err_slot_q, hstrps_pkg::ST_RANGE);
				stb_d = 1'b1;
				state_d = S_RUN;
			end
			S_DRV_RD: begin
				state_d = S_DRV_EV;
			end
			S_DRV_EV: begin
				dp = {step_q[15], step_q} + (drv_step ? 17'd0 : {drd_q[15], drd_q[15:0]});
				ok = drv_hi ? (!dp[16] && dp != 17'd0) : dp[16];
				state_d = S_DRV_RD;
				if ({1'b0, kcnt_q} < {1'b0, drv_len} && ok && frd_q[1]) begin
					n = drv_hi ? nh_q : nl_q;
					if (n >= DPB5) begin
						out_d = hstrps_pkg::make_err(work_slot_q, hstrps_pkg::ST_MANY);
						stb_d = 1'b1;
						state_d = S_RUN;
					end else if (dp[16] != dp[15]) begin
						out_d = hstrps_pkg::make_err(work_slot_q, hstrps_pkg::ST_RANGE);
						stb_d = 1'b1;
						state_d = S_RUN;
					end else begin
						dm_we = 1'b1;
						dm_wa = {work_slot_q, drv_hi, n[3:0]};
						dm_wd = {frd_q[0], dp[15:0]};
						if (drv_hi) begin
							nh = nh_q + 5'd1;
						end else begin
							nl = nl_q + 5'd1;
						end
					end
				end
				if (state_d != S_RUN) begin
					if (kcnt_q + 5'd1 < drv_len) begin
						kcnt_d = kcnt_q + 5'd1;
					end else if (pass_q == 3'd5) begin
						cm_we = 1'b1;
						cm_wa = work_slot_q;
						cm_wd = {nh, nl};
						em_list_d = (nl == 5'd0);
						em_pos_d = '0;
						state_d = S_EMIT_RD;
					end else begin
						pass_d = pass_q + 3'd1;
						kcnt_d = '0;
					end
				end
				nl_d = nl;
				nh_d = nh;
			end
			S_EMIT_RD: begin
				dm_ra = {work_slot_q, em_list_q, em_pos_q};
				if (nl_q == 5'd0 && nh_q == 5'd0) begin
					out_d = '0;
					out_d.set_out = work_slot_q;
					out_d.status = hstrps_pkg::ST_OK;
					out_d.last = 1'b1;
					stb_d = 1'b1;
					state_d = S_RUN;
				end else begin
					state_d = S_EMIT_OUT;
				end
			end
			S_EMIT_OUT: begin
				if (em_list_q) begin
					lst = ({1'b0, em_pos_q} + 5'd1) == nh_q;
				end else begin
					lst = (nh_q == 5'd0) && (({1'b0, em_pos_q} + 5'd1) == nl_q);
				end
				out_d.set_out = work_slot_q;
				out_d.list_select = em_list_q;
				out_d.entry_position = em_pos_q;
				out_d.poc_delta = drd_q[15:0];
				out_d.used_now = drd_q[16];
				out_d.entry_valid = 1'b1;
				out_d.status = hstrps_pkg::ST_OK;
				out_d.last = lst;
				stb_d = 1'b1;
				if (lst) begin
					state_d = S_RUN;
				end else begin
					state_d = S_EMIT_RD;
					if (!em_list_q && (({1'b0, em_pos_q} + 5'd1) == nl_q)) begin
						em_list_d = 1'b1;
						em_pos_d = '0;
					end else begin
						em_pos_d = em_pos_q + 4'd1;
					end
				end
			end
			default: begin
				state_d = S_RUN;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dm_we) begin
			dmem[dm_wa] <= dm_wd;
		end
		drd_q <= dmem[dm_ra];
		if (cm_we) begin
			cmem[cm_wa] <= cm_wd;
		end
		crd_q <= cmem[ref_slot_q];
		if (fm_we) begin
			fmem[fm_wa] <= fm_wd;
		end
		frd_q <= fmem[fm_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
			ph_q <= PH_IDLE;
			cfg_q <= '0;
			work_slot_q <= '0;
			ref_slot_q <= '0;
			err_slot_q <= '0;
			slice_q <= 1'b0;
			sign_q <= 1'b0;
			neg_q <= '0;
			pos_q <= '0;
			ref_neg_q <= '0;
			ref_pos_q <= '0;
			nl_q <= '0;
			nh_q <= '0;
			poc_q <= '0;
			step_q <= '0;
			loop_q <= '0;
			pass_q <= '0;
			kcnt_q <= '0;
			em_list_q <= 1'b0;
			em_pos_q <= '0;
			out_q <= '0;
			stb_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			state_q <= state_d;
			ph_q <= ph_d;
			work_slot_q <= work_slot_d;
			ref_slot_q <= ref_slot_d;
			err_slot_q <= err_slot_d;
			slice_q <= slice_d;
			sign_q <= sign_d;
			neg_q <= neg_d;
			pos_q <= pos_d;
			ref_neg_q <= ref_neg_d;
			ref_pos_q <= ref_pos_d;
			nl_q <= nl_d;
			nh_q <= nh_d;
			poc_q <= poc_d;
			step_q <= step_d;
			loop_q <= loop_d;
			pass_q <= pass_d;
			kcnt_q <= kcnt_d;
			em_list_q <= em_list_d;
			em_pos_q <= em_pos_d;
			out_q <= out_d;
			stb_q <= stb_d;
		end
	end

	a_emit_beat: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT_OUT |=> done && result.entry_valid)
		else $error("entry read did not produce a result beat");

	a_invalid_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.entry_valid |-> result.last)
		else $error("empty or error beat not marked last");

	a_entry_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.entry_valid |-> result.status == hstrps_pkg::ST_OK)
		else $error("entry beat carries an error status");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nl_q <= DPB5 && nh_q <= DPB5)
		else $error("derived list count exceeds the picture buffer size");

endmodule
